// File: rtl/vhfp_pkg.sv
// Package for the VOL header field parser: parse phases, aspect table,
// shared word types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vhfp_pkg;

  localparam int unsigned FifoDepth = 4;

  // status codes
  localparam logic [1:0] STAT_RECT    = 2'd0;
  localparam logic [1:0] STAT_NONRECT = 2'd1;
  localparam logic [1:0] STAT_NONE    = 2'd2;
  localparam logic [1:0] STAT_TRUNC   = 2'd3;

  // start code tail after 00 00 01
  localparam logic [23:0] SC_PREFIX = 24'h000001;
  localparam logic [7:0]  SC_VOL    = 8'h20;
  localparam logic [3:0]  ASPECT_EXT = 4'hF;

  typedef enum logic [5:0] {
    PH_SEARCH, PH_RA, PH_TYPE, PH_OLID, PH_VER, PH_PRIO, PH_ASPECT,
    PH_PARW, PH_PARH, PH_CTRL, PH_CHROMA, PH_LOWDELAY, PH_VBV,
    PH_SKIP1, PH_SKIP2, PH_SKIP3, PH_SKIP4, PH_SKIP5,
    PH_SHAPE, PH_SHAPEEXT, PH_MARK1, PH_DEN, PH_MARK2, PH_FIXED, PH_SCALE,
    PH_MW, PH_WIDTH, PH_MH, PH_HEIGHT, PH_MEND, PH_INTER, PH_OBMC,
    PH_SPRITE, PH_DONE
  } phase_t;

  // word passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hit;      // start code completes on this byte
    logic       search;   // byte seen while searching
  } cls_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [7:0]  aspect_numerator;
    logic [7:0]  aspect_denominator;
    logic [15:0] time_rate;
    logic [15:0] time_scale;
    logic [1:0]  sprite_mode;
    logic        gmc_format;
  } res_t;

  function automatic logic [15:0] par_lookup(input logic [3:0] code);
    logic [15:0] r;
    case (code)
      4'd1:    r = {8'd1, 8'd1};
      4'd2:    r = {8'd12, 8'd11};
      4'd3:    r = {8'd10, 8'd11};
      4'd4:    r = {8'd16, 8'd11};
      4'd5:    r = {8'd40, 8'd33};
      default: r = {8'd0, 8'd1};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/vhfp_if.sv
// Valid/ready channel interface carrying a generic payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface vhfp_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/vhfp_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module vhfp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/vhfp_front.sv
// Front end: start code search over the byte stream, classifies each byte.
// Depends on vhfp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vhfp_front
  import vhfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            push,
  output cls_t            push_word,
  input  wire logic       full
);
  logic [23:0] window;
  logic        searching;   // front's own view: no start code yet this buffer
  logic        acc;
  logic        hit;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;
  assign hit      = searching && window == SC_PREFIX && in_byte == SC_VOL;
  assign push     = acc;
  assign push_word = '{data: in_byte, last: in_last, hit: hit, search: searching};

  // track window and search state; rearm at last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      searching <= 1'b1;
    end else if (acc) begin
      if (in_last) begin
        window    <= '0;
        searching <= 1'b1;
      end else if (searching) begin
        window <= {window[15:0], in_byte};
        if (hit) searching <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/vhfp_back.sv
// Back end: bit-serial header field parser, one byte of bits a word.
// Depends on vhfp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vhfp_back
  import vhfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic pop_valid,
  output logic      pop,
  input  wire cls_t pop_word,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);
  phase_t      phase;
  logic [3:0]  bitcnt;     // 0 = idle, else next bit index+1
  logic [7:0]  sbyte;
  logic        slast;
  logic [4:0]  left;
  logic [15:0] accum;
  logic [3:0]  ver;
  logic [1:0]  shape;
  logic [3:0]  incw;
  logic        done;
  logic [15:0] rate, scale;
  logic [7:0]  num, den;
  logic [12:0] width, height;
  logic [4:0]  dw;

  logic busy;
  assign busy   = bitcnt != 4'd0;
  assign pop    = pop_valid && !busy && !out_valid;

  logic        bitv;
  logic [15:0] acc_n;
  logic [4:0]  left_n;
  logic        verone;
  assign bitv   = sbyte[3'(bitcnt - 4'd1)];
  assign acc_n  = {accum[14:0], bitv};
  assign left_n = (left != 5'd0) ? left - 5'd1 : 5'd0;
  assign verone = ver == 4'd1;

  // highest set bit of rate-1 (bit width minus one) for the fixed increment
  always_comb begin
    logic [15:0] t;
    t  = acc_n - 16'd1;
    dw = 5'd0;
    for (int i = 15; i >= 1; i--) begin
      if (t[i] && dw == 5'd0) dw = 5'(i);
    end
  end

  // one header bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH; bitcnt <= '0; done <= 1'b0; out_valid <= 1'b0;
      left <= '0; accum <= '0; ver <= '0; shape <= '0; incw <= '0;
      rate <= '0; scale <= '0; num <= '0; den <= '0; width <= '0; height <= '0;
      slast <= 1'b0; sbyte <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (pop) begin
        if (pop_word.search) begin
          if (pop_word.hit && !pop_word.last) begin
            phase <= PH_RA; left <= 5'd1; accum <= '0;
          end
          if (pop_word.last) begin
            out_valid <= 1'b1;
            out_res   <= '{status: pop_word.hit ? STAT_TRUNC : STAT_NONE, default: '0};
            phase <= PH_SEARCH;
          end
        end else if (done) begin
          if (pop_word.last) begin
            phase <= PH_SEARCH; done <= 1'b0;
            ver <= '0; shape <= '0; incw <= '0; rate <= '0; scale <= '0;
            num <= '0; den <= '0; width <= '0; height <= '0;
          end
        end else begin
          sbyte <= pop_word.data; slast <= pop_word.last; bitcnt <= 4'd8;
        end
      end else if (busy) begin
        logic        fin, emit, stop;
        logic [1:0]  spr;
        fin = left_n == 5'd0; emit = 1'b0; stop = 1'b0; spr = 2'd0;
        accum <= acc_n; left <= left_n;
        if (fin) begin
          accum <= '0;
          case (phase)
            PH_RA:    begin phase <= PH_TYPE; left <= 5'd8; end
            PH_TYPE:  begin phase <= PH_OLID; left <= 5'd1; end
            PH_OLID:  if (acc_n[0]) begin phase <= PH_VER; left <= 5'd4; end
                      else begin ver <= 4'd1; phase <= PH_ASPECT; left <= 5'd4; end
            PH_VER:   begin ver <= acc_n[3:0]; phase <= PH_PRIO; left <= 5'd3; end
            PH_PRIO:  begin phase <= PH_ASPECT; left <= 5'd4; end
            PH_ASPECT:
              if (acc_n[3:0] == ASPECT_EXT) begin phase <= PH_PARW; left <= 5'd8; end
              else begin
                {num, den} <= par_lookup(acc_n[3:0]);
                phase <= PH_CTRL; left <= 5'd1;
              end
            PH_PARW:  begin num <= acc_n[7:0]; phase <= PH_PARH; left <= 5'd8; end
            PH_PARH:  begin den <= acc_n[7:0]; phase <= PH_CTRL; left <= 5'd1; end
            PH_CTRL:  if (acc_n[0]) begin phase <= PH_CHROMA; left <= 5'd2; end
                      else begin phase <= PH_SHAPE; left <= 5'd2; end
            PH_CHROMA:   begin phase <= PH_LOWDELAY; left <= 5'd1; end
            PH_LOWDELAY: begin phase <= PH_VBV; left <= 5'd1; end
            PH_VBV:   if (acc_n[0]) begin phase <= PH_SKIP1; left <= 5'd16; end
                      else begin phase <= PH_SHAPE; left <= 5'd2; end
            PH_SKIP1: begin phase <= PH_SKIP2; left <= 5'd16; end
            PH_SKIP2: begin phase <= PH_SKIP3; left <= 5'd16; end
            PH_SKIP3: begin phase <= PH_SKIP4; left <= 5'd16; end
            PH_SKIP4: begin phase <= PH_SKIP5; left <= 5'd15; end
            PH_SKIP5: begin phase <= PH_SHAPE; left <= 5'd2; end
            PH_SHAPE: begin
              shape <= acc_n[1:0];
              if (acc_n[1:0] == 2'd3 && !verone) begin phase <= PH_SHAPEEXT; left <= 5'd4; end
              else begin phase <= PH_MARK1; left <= 5'd1; end
            end
            PH_SHAPEEXT: begin phase <= PH_MARK1; left <= 5'd1; end
            PH_MARK1: begin phase <= PH_DEN; left <= 5'd16; end
            PH_DEN:   begin
              rate <= acc_n; incw <= dw[3:0]; phase <= PH_MARK2; left <= 5'd1;
            end
            PH_MARK2: begin phase <= PH_FIXED; left <= 5'd1; end
            PH_FIXED, PH_SCALE: begin
              if (phase == PH_FIXED && acc_n[0]) begin
                phase <= PH_SCALE; left <= {1'b0, incw} + 5'd1;
              end else begin
                scale <= (phase == PH_FIXED) ? 16'd1 : acc_n;
                if (shape == 2'd2) emit = 1'b1;
                else if (shape == 2'd0) begin phase <= PH_MW; left <= 5'd1; end
                else begin phase <= PH_INTER; left <= 5'd1; end
              end
            end
            PH_MW:     begin phase <= PH_WIDTH; left <= 5'd13; end
            PH_WIDTH:  begin width <= acc_n[12:0]; phase <= PH_MH; left <= 5'd1; end
            PH_MH:     begin phase <= PH_HEIGHT; left <= 5'd13; end
            PH_HEIGHT: begin height <= acc_n[12:0]; phase <= PH_MEND; left <= 5'd1; end
            PH_MEND:   begin phase <= PH_INTER; left <= 5'd1; end
            PH_INTER:  begin phase <= PH_OBMC; left <= 5'd1; end
            PH_OBMC:   begin phase <= PH_SPRITE; left <= verone ? 5'd1 : 5'd2; end
            PH_SPRITE: begin emit = 1'b1; spr = acc_n[1:0]; end
            default:   begin stop = 1'b1; end
          endcase
        end
        if (emit) begin
          out_valid <= 1'b1;
          out_res.status <= (shape == 2'd0) ? STAT_RECT : STAT_NONRECT;
          out_res.frame_width  <= (shape == 2'd0) ? width : 13'd0;
          out_res.frame_height <= (shape == 2'd0) ? height : 13'd0;
          out_res.aspect_numerator   <= num;
          out_res.aspect_denominator <= den;
          out_res.time_rate  <= rate;
          out_res.time_scale <= (phase == PH_FIXED) ? 16'd1 :
                                (phase == PH_SCALE) ? acc_n : scale;
          out_res.sprite_mode <= spr;
          out_res.gmc_format  <= spr == 2'd1 || spr == 2'd2;
          phase <= PH_DONE;
        end
        if (emit || stop || bitcnt == 4'd1) begin
          bitcnt <= '0;
          if (slast) begin
            phase <= PH_SEARCH; done <= 1'b0; left <= '0; accum <= '0;
            ver <= '0; shape <= '0; incw <= '0; rate <= '0; scale <= '0;
            num <= '0; den <= '0; width <= '0; height <= '0;
            if (!emit && !done) begin
              out_valid <= 1'b1;
              out_res   <= '{status: STAT_TRUNC, default: '0};
            end
          end else if (emit) begin
            done <= 1'b1;
          end
        end else begin
          bitcnt <= bitcnt - 4'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/vol_header_field_parser.sv
// Top level of the VOL header field parser: front end, word queue, back end.
// Depends on vhfp_pkg, vhfp_if, vhfp_ram, vhfp_front, vhfp_back.
`timescale 1ns / 1ps
`default_nettype none
// Bytes enter on in_ch and searching for the 00 00 01 20 start code takes one
// byte per cycle while the queue has room. Once a start code is seen, the
// back end walks the header one bit per cycle, loading each header byte
// before its bits are taken; bytes after the result, up to last_byte, drain
// at one per cycle once the result is taken. A result waiting on out_ch holds
// the back end, so the queue fills and in_ch stalls until the result is taken.
// A queue of Depth words (FifoDepth by default, a small RAM) sits between the
// search and the bit parser. One result is given for every buffer that ends with last_byte.
module vol_header_field_parser
  import vhfp_pkg::*;
#(
  parameter int unsigned Depth = FifoDepth
) (
  input wire logic clk,
  input wire logic rst,
  vhfp_if.sink   in_ch,
  vhfp_if.source out_ch
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $bits(cls_t);

  logic      push, full, pop, pop_valid;
  cls_t      push_word, pop_word;
  logic [AW-1:0] wp, rp, rp_n;
  logic [AW:0]   cnt;
  logic [CW-1:0] rdata;

  vhfp_front u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte(in_ch.payload.stream_byte), .in_last(in_ch.payload.last_byte),
    .push, .push_word, .full
  );

  // queue pointers; read address runs one ahead for the registered read
  assign full      = cnt == (AW+1)'(Depth);
  assign pop_valid = cnt != '0;
  assign rp_n      = pop ? ((rp == AW'(Depth-1)) ? '0 : rp + 1'b1) : rp;
  assign pop_word  = cls_t'(rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      rp  <= rp_n;
      cnt <= cnt + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  // bypass a word written at the address being read
  logic          byp;
  logic [CW-1:0] byp_data, mem_q;
  always_ff @(posedge clk) begin
    byp      <= push && wp == rp_n;
    byp_data <= push_word;
  end
  assign rdata = byp ? byp_data : mem_q;

  vhfp_ram #(.Width(CW), .Depth(Depth)) u_ram (
    .clk, .we(push), .waddr(wp), .wdata(push_word), .raddr(rp_n), .rdata(mem_q)
  );

  res_t res;
  vhfp_back u_back (
    .clk, .rst, .pop_valid, .pop, .pop_word,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  always_comb begin
    out_ch.payload.status             = res.status;
    out_ch.payload.frame_width        = res.frame_width;
    out_ch.payload.frame_height       = res.frame_height;
    out_ch.payload.aspect_numerator   = res.aspect_numerator;
    out_ch.payload.aspect_denominator = res.aspect_denominator;
    out_ch.payload.time_rate          = res.time_rate;
    out_ch.payload.time_scale         = res.time_scale;
    out_ch.payload.sprite_mode        = res.sprite_mode;
    out_ch.payload.gmc_format         = res.gmc_format;
  end
endmodule
`default_nettype wire

// File: rtl/vhfp_checker.sv
// Port checker for the VOL header field parser, bound to the top level.
// Depends on vhfp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vhfp_checker
  import vhfp_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0]  status,
  input wire logic [12:0] frame_width,
  input wire logic [1:0]  sprite_mode,
  input wire logic        gmc_format
);
  // a held result keeps its status and frame width
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(status) && $stable(frame_width))
    else $error("result changed while stalled");
  // gmc flag follows the sprite mode
  a_gmc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gmc_format == (sprite_mode == 2'd1 || sprite_mode == 2'd2))
    else $error("gmc flag mismatch");
  // failure results carry no size
  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_NONE || status == STAT_TRUNC) |-> frame_width == '0)
    else $error("size on failure result");
  // nothing valid straight out of reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
  // empty queue takes input straight out of reset
  a_rdy: assert property (@(posedge clk) rst |=> in_ready || !in_valid || in_ready)
    else $error("input blocked after reset");
endmodule

bind vol_header_field_parser vhfp_checker u_chk (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.payload.status), .frame_width(out_ch.payload.frame_width),
  .sprite_mode(out_ch.payload.sprite_mode), .gmc_format(out_ch.payload.gmc_format)
);
`default_nettype wire
